// ===== rtl/triangle_tangent_frame_core_defines.svh =====
// Assertion macros shared by the tangent frame RTL.
// Included by modules that carry concurrent checks; needs nothing else.
`ifndef TRIANGLE_TANGENT_FRAME_CORE_DEFINES_SVH
`define TRIANGLE_TANGENT_FRAME_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TTF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define TTF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define TTF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TTF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/ttf_pkg.sv =====
// Shared types and constants of the triangle tangent frame block.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package ttf_pkg;

    localparam int COORD_W  = 32;
    localparam int OUT_FRAC = 14;
    localparam int OUT_W    = 16;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int TERM_W   = PROD_W + 1;
    localparam int V_W      = 31;
    localparam int SUM_W    = 64;
    localparam int ROOT_W   = 32;
    localparam int QW       = OUT_FRAC + 1;
    localparam int NUM_W    = V_W + QW + 1;
    localparam int REM_W    = ROOT_W + 2;
    localparam int SQRT_STEPS = SUM_W / 2;
    localparam int CNT_W    = $clog2(SQRT_STEPS);
    localparam int IDX_W    = 5;
    localparam int TERM_LAST = 6;
    localparam logic [IDX_W-1:0] IDX_SQ0 = 5'd14;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] tex_u;
        logic signed [COORD_W-1:0] tex_v;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] tan_x;
        logic signed [OUT_W-1:0] tan_y;
        logic signed [OUT_W-1:0] tan_z;
        logic signed [OUT_W-1:0] bitan_x;
        logic signed [OUT_W-1:0] bitan_y;
        logic signed [OUT_W-1:0] bitan_z;
        logic                    degenerate;
        logic [1:0]              corner;
        logic                    last;
    } t_out_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] tan_x;
        logic signed [OUT_W-1:0] tan_y;
        logic signed [OUT_W-1:0] tan_z;
        logic signed [OUT_W-1:0] bitan_x;
        logic signed [OUT_W-1:0] bitan_y;
        logic signed [OUT_W-1:0] bitan_z;
        logic                    degenerate;
    } t_frame;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_HOLD0,
        OP_HOLD1,
        OP_DIFF,
        OP_MUL,
        OP_MUL_ACC,
        OP_STORE,
        OP_NINIT,
        OP_NSHIFT,
        OP_SUM,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_STORE,
        OP_DEGEN
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic det_zero;
        logic vec_zero;
        logic vec_big;
        logic len_zero;
    } t_dp_stat;

endpackage

// ===== rtl/ttf_dp.sv =====
// Datapath of the tangent frame block: held corners, shared multiplier,
// normalising shifter, square root and divider. Depends on ttf_pkg.
`timescale 1ns / 1ps
module ttf_dp (
    input  logic              i_clk,
    input  ttf_pkg::t_dp_cmd  i_cmd,
    input  ttf_pkg::t_in_item i_in_data,
    output ttf_pkg::t_dp_stat o_stat,
    output ttf_pkg::t_frame   o_frame
);
    import ttf_pkg::*;

    t_in_item                  r_h0;
    t_in_item                  r_h1;
    logic signed [DIFF_W-1:0]  r_e1 [3];
    logic signed [DIFF_W-1:0]  r_e2 [3];
    logic signed [DIFF_W-1:0]  r_du1, r_dv1, r_du2, r_dv2;
    logic signed [PROD_W-1:0]  r_prod, r_acc;
    logic signed [TERM_W-1:0]  r_term [7];
    logic [TERM_W-1:0]         r_m [3];
    logic [2:0]                r_sgn;
    logic [SUM_W-1:0]          r_sum, r_x, r_root, r_bit;
    logic [REM_W-1:0]          r_rem;
    logic [QW-1:0]             r_nlo, r_q;
    logic [1:0]                r_dj;
    logic signed [OUT_W-1:0]   r_res [6];
    logic                      r_degen;

    logic signed [DIFF_W-1:0]  w_a, w_b;
    logic signed [TERM_W-1:0]  w_c [3];
    logic [SUM_W:0]            w_trial;
    logic [ROOT_W-1:0]         w_len;
    logic [NUM_W-1:0]          w_num;
    logic [REM_W-1:0]          w_t, w_d;
    logic [TERM_W-1:0]         w_or;

    function automatic logic signed [DIFF_W-1:0] f_sub(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        f_sub = DIFF_W'(a) - DIFF_W'(b);
    endfunction

    // Operand selection for the shared multiplier.
    always_comb begin
        w_a = '0;
        w_b = '0;
        unique case (i_cmd.idx)
            5'd0:  begin w_a = r_du1; w_b = r_dv2; end
            5'd1:  begin w_a = r_du2; w_b = r_dv1; end
            5'd2:  begin w_a = r_dv2; w_b = r_e1[0]; end
            5'd3:  begin w_a = r_dv1; w_b = r_e2[0]; end
            5'd4:  begin w_a = r_dv2; w_b = r_e1[1]; end
            5'd5:  begin w_a = r_dv1; w_b = r_e2[1]; end
            5'd6:  begin w_a = r_dv2; w_b = r_e1[2]; end
            5'd7:  begin w_a = r_dv1; w_b = r_e2[2]; end
            5'd8:  begin w_a = r_du1; w_b = r_e2[0]; end
            5'd9:  begin w_a = r_du2; w_b = r_e1[0]; end
            5'd10: begin w_a = r_du1; w_b = r_e2[1]; end
            5'd11: begin w_a = r_du2; w_b = r_e1[1]; end
            5'd12: begin w_a = r_du1; w_b = r_e2[2]; end
            5'd13: begin w_a = r_du2; w_b = r_e1[2]; end
            5'd14: begin
                w_a = DIFF_W'(r_m[0][V_W-1:0]);
                w_b = DIFF_W'(r_m[0][V_W-1:0]);
            end
            5'd15: begin
                w_a = DIFF_W'(r_m[1][V_W-1:0]);
                w_b = DIFF_W'(r_m[1][V_W-1:0]);
            end
            5'd16: begin
                w_a = DIFF_W'(r_m[2][V_W-1:0]);
                w_b = DIFF_W'(r_m[2][V_W-1:0]);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    // Vector chosen for normalisation, divider and root arithmetic.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_c[i] = i_cmd.idx[0] ? r_term[4 + i] : r_term[1 + i];
        end
        w_trial = {1'b0, r_root} + {1'b0, r_bit};
        w_len   = r_root[ROOT_W-1:0];
        w_num   = NUM_W'({r_m[i_cmd.idx[1:0]][V_W-1:0], {QW{1'b0}}}) + NUM_W'(w_len);
        w_t     = {r_rem[REM_W-2:0], r_nlo[QW-1]};
        w_d     = REM_W'({w_len, 1'b0});
        w_or    = r_m[0] | r_m[1] | r_m[2];
    end

    // Datapath registers, each updated by its command.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_HOLD0: r_h0 <= i_in_data;
            OP_HOLD1: r_h1 <= i_in_data;
            OP_DIFF: begin
                r_e1[0] <= f_sub(r_h1.pos_x, r_h0.pos_x);
                r_e1[1] <= f_sub(r_h1.pos_y, r_h0.pos_y);
                r_e1[2] <= f_sub(r_h1.pos_z, r_h0.pos_z);
                r_e2[0] <= f_sub(i_in_data.pos_x, r_h0.pos_x);
                r_e2[1] <= f_sub(i_in_data.pos_y, r_h0.pos_y);
                r_e2[2] <= f_sub(i_in_data.pos_z, r_h0.pos_z);
                r_du1   <= f_sub(r_h1.tex_u, r_h0.tex_u);
                r_dv1   <= f_sub(r_h1.tex_v, r_h0.tex_v);
                r_du2   <= f_sub(i_in_data.tex_u, r_h0.tex_u);
                r_dv2   <= f_sub(i_in_data.tex_v, r_h0.tex_v);
                r_degen <= 1'b0;
            end
            OP_MUL: r_prod <= w_a * w_b;
            OP_MUL_ACC: begin
                r_acc  <= r_prod;
                r_prod <= w_a * w_b;
            end
            OP_STORE: r_term[i_cmd.idx[2:0]] <= TERM_W'(r_acc) - TERM_W'(r_prod);
            OP_NINIT: begin
                for (int i = 0; i < 3; i++) begin
                    r_m[i]   <= w_c[i][TERM_W-1] ? -w_c[i] : w_c[i];
                    r_sgn[i] <= w_c[i][TERM_W-1] ^ r_term[0][TERM_W-1];
                end
            end
            OP_NSHIFT: begin
                for (int i = 0; i < 3; i++) begin
                    r_m[i] <= r_m[i] >> 1;
                end
            end
            OP_SUM: r_sum <= ((i_cmd.idx == '0) ? '0 : r_sum) + r_prod[SUM_W-1:0];
            OP_SQRT_INIT: begin
                r_x    <= r_sum;
                r_root <= '0;
                r_bit  <= SUM_W'(1) << (SUM_W - 2);
            end
            OP_SQRT_STEP: begin
                if ({1'b0, r_x} >= w_trial) begin
                    r_x    <= r_x - w_trial[SUM_W-1:0];
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_DIV_INIT: begin
                r_dj  <= i_cmd.idx[1:0];
                r_rem <= REM_W'(w_num[NUM_W-1:QW]);
                r_nlo <= w_num[QW-1:0];
                r_q   <= '0;
            end
            OP_DIV_STEP: begin
                if (w_t >= w_d) begin
                    r_rem <= w_t - w_d;
                end else begin
                    r_rem <= w_t;
                end
                r_nlo <= r_nlo << 1;
                r_q   <= {r_q[QW-2:0], (w_t >= w_d)};
            end
            OP_DIV_STORE: begin
                r_res[i_cmd.idx[2:0]] <= r_sgn[r_dj] ? -OUT_W'(r_q) : OUT_W'(r_q);
            end
            OP_DEGEN: begin
                for (int i = 0; i < 6; i++) begin
                    r_res[i] <= '0;
                end
                r_degen <= 1'b1;
            end
            default: ;
        endcase
    end

    // Status back to the controller.
    assign o_stat.det_zero = (r_term[0] == '0);
    assign o_stat.vec_zero = (w_or == '0);
    assign o_stat.vec_big  = |w_or[TERM_W-1:V_W];
    assign o_stat.len_zero = (r_root == '0);

    assign o_frame.tan_x      = r_res[0];
    assign o_frame.tan_y      = r_res[1];
    assign o_frame.tan_z      = r_res[2];
    assign o_frame.bitan_x    = r_res[3];
    assign o_frame.bitan_y    = r_res[4];
    assign o_frame.bitan_z    = r_res[5];
    assign o_frame.degenerate = r_degen;

endmodule

// ===== rtl/ttf_ctrl.sv =====
// Controller of the tangent frame block: vertex slots, compute sequence
// and the three-result output phase. Depends on ttf_pkg and the defines header.
`timescale 1ns / 1ps
`include "triangle_tangent_frame_core_defines.svh"
module ttf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_corner,
    output logic              o_last,
    output ttf_pkg::t_dp_cmd  o_cmd,
    input  ttf_pkg::t_dp_stat i_stat
);
    import ttf_pkg::*;

    localparam logic [1:0] SLOT_C0 = 2'd0;
    localparam logic [1:0] SLOT_C1 = 2'd1;
    localparam logic [1:0] SLOT_C2 = 2'd2;
    localparam logic [1:0] CORNER_LAST = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_A, S_MUL_B, S_STORE, S_CHK_DET, S_NINIT, S_NCHK,
        S_SQ, S_SQADD, S_SQINIT, S_SQRT, S_LCHK, S_DINIT, S_DSTEP,
        S_DSTORE, S_EMIT
    } t_state;

    t_state           r_state, n_state;
    logic [1:0]       r_slot, n_slot;
    logic [2:0]       r_term, n_term;
    logic [1:0]       r_j, n_j;
    logic             r_vs, n_vs;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_corner, n_corner;
    logic             w_in_acc;

    assign o_in_stall = !((r_state == S_IDLE) ||
                          ((r_state == S_EMIT) && (r_slot != SLOT_C2)));
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        n_slot     = r_slot;
        n_term     = r_term;
        n_j        = r_j;
        n_vs       = r_vs;
        n_cnt      = r_cnt;
        n_corner   = r_corner;
        o_cmd.op   = OP_NONE;
        o_cmd.idx  = '0;

        if (w_in_acc) begin
            unique case (r_slot)
                SLOT_C1: begin
                    o_cmd.op = OP_HOLD1;
                    n_slot   = SLOT_C2;
                end
                SLOT_C2: begin
                    o_cmd.op = OP_DIFF;
                    n_slot   = SLOT_C0;
                    n_term   = '0;
                    n_state  = S_MUL_A;
                end
                default: begin
                    o_cmd.op = OP_HOLD0;
                    n_slot   = SLOT_C1;
                end
            endcase
        end

        unique case (r_state)
            S_IDLE: ;
            S_MUL_A: begin
                o_cmd.op  = OP_MUL;
                o_cmd.idx = IDX_W'({r_term, 1'b0});
                n_state   = S_MUL_B;
            end
            S_MUL_B: begin
                o_cmd.op  = OP_MUL_ACC;
                o_cmd.idx = IDX_W'({r_term, 1'b1});
                n_state   = S_STORE;
            end
            S_STORE: begin
                o_cmd.op  = OP_STORE;
                o_cmd.idx = IDX_W'(r_term);
                if (r_term == 3'(TERM_LAST)) begin
                    n_state = S_CHK_DET;
                end else begin
                    n_term  = r_term + 3'd1;
                    n_state = S_MUL_A;
                end
            end
            S_CHK_DET: begin
                n_vs = 1'b0;
                if (i_stat.det_zero) begin
                    o_cmd.op = OP_DEGEN;
                    n_state  = S_EMIT;
                end else begin
                    n_state = S_NINIT;
                end
            end
            S_NINIT: begin
                o_cmd.op  = OP_NINIT;
                o_cmd.idx = IDX_W'(r_vs);
                n_state   = S_NCHK;
            end
            S_NCHK: begin
                n_j = '0;
                if (i_stat.vec_zero) begin
                    o_cmd.op = OP_DEGEN;
                    n_state  = S_EMIT;
                end else if (i_stat.vec_big) begin
                    o_cmd.op = OP_NSHIFT;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.op  = OP_MUL;
                o_cmd.idx = IDX_SQ0 + IDX_W'(r_j);
                n_state   = S_SQADD;
            end
            S_SQADD: begin
                o_cmd.op  = OP_SUM;
                o_cmd.idx = IDX_W'(r_j);
                if (r_j == 2'd2) begin
                    n_state = S_SQINIT;
                end else begin
                    n_j     = r_j + 2'd1;
                    n_state = S_SQ;
                end
            end
            S_SQINIT: begin
                o_cmd.op = OP_SQRT_INIT;
                n_cnt    = '0;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT_STEP;
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_state = S_LCHK;
                end
            end
            S_LCHK: begin
                n_j = '0;
                if (i_stat.len_zero) begin
                    o_cmd.op = OP_DEGEN;
                    n_state  = S_EMIT;
                end else begin
                    n_state = S_DINIT;
                end
            end
            S_DINIT: begin
                o_cmd.op  = OP_DIV_INIT;
                o_cmd.idx = IDX_W'(r_j);
                n_cnt     = '0;
                n_state   = S_DSTEP;
            end
            S_DSTEP: begin
                o_cmd.op = OP_DIV_STEP;
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(QW - 1)) begin
                    n_state = S_DSTORE;
                end
            end
            S_DSTORE: begin
                o_cmd.op  = OP_DIV_STORE;
                o_cmd.idx = IDX_W'({1'b0, r_j} + (r_vs ? 3'd3 : 3'd0));
                if (r_j != 2'd2) begin
                    n_j     = r_j + 2'd1;
                    n_state = S_DINIT;
                end else if (!r_vs) begin
                    n_vs    = 1'b1;
                    n_state = S_NINIT;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_out_stall) begin
                    if (r_corner == CORNER_LAST) begin
                        n_corner = '0;
                        n_state  = S_IDLE;
                    end else begin
                        n_corner = r_corner + 2'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_slot     <= SLOT_C0;
            r_term     <= '0;
            r_j        <= '0;
            r_vs       <= 1'b0;
            r_cnt      <= '0;
            r_corner   <= '0;
        end else begin
            r_state    <= n_state;
            r_slot     <= n_slot;
            r_term     <= n_term;
            r_j        <= n_j;
            r_vs       <= n_vs;
            r_cnt      <= n_cnt;
            r_corner   <= n_corner;
        end
    end

    // The degenerate clear is issued by the check states, so the frame is
    // already settled when the emit phase begins.
    assign o_out_valid = (r_state == S_EMIT);
    assign o_corner    = r_corner;
    assign o_last      = (r_corner == CORNER_LAST);

    `TTF_ASSERT_NXT(a_third_starts, i_clk, i_rst_n, w_in_acc && (r_slot == SLOT_C2), r_state == S_MUL_A)
    `TTF_ASSERT_NXT(a_emit_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(r_corner))
    `TTF_ASSERT_NXT(a_last_ends, i_clk, i_rst_n, o_out_valid && !i_out_stall && o_last, r_state == S_IDLE)
    `TTF_ASSERT_IMP(a_no_third_in_emit, i_clk, i_rst_n, r_state == S_EMIT, o_in_stall || (r_slot != SLOT_C2))

endmodule

// ===== rtl/triangle_tangent_frame_core.sv =====
// Top level of the triangle tangent frame block.
// Joins ttf_ctrl and ttf_dp; depends on ttf_pkg.
//
//   Channel  Valid        Stall        Payload
//   input    i_in_valid   o_in_stall   i_in_data  (ttf_pkg::t_in_item)
//   output   o_out_valid  i_out_stall  o_out_data (ttf_pkg::t_out_item)
//
// The first two corners of a triangle are held as they arrive, also while the
// previous frame is still being delivered. The third corner starts the work
// (shorter when the UV determinant is zero), set by the one shared
// multiplier, the bit-pair square root and the radix-2 divider, with
// normalising shifts per vector.
// Reset is synchronous and active low and returns to the first corner.
// A stalled output transaction holds its data and its corner.
`timescale 1ns / 1ps
module triangle_tangent_frame_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ttf_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ttf_pkg::t_out_item o_out_data
);
    import ttf_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_stat   w_stat;
    t_frame     w_frame;
    logic [1:0] w_corner;
    logic       w_last;

    ttf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_corner    (w_corner),
        .o_last      (w_last),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    ttf_dp u_dp (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_in_data (i_in_data),
        .o_stat    (w_stat),
        .o_frame   (w_frame)
    );

    // Result transaction: frame from the datapath, position from the controller.
    assign o_out_data.tan_x      = w_frame.tan_x;
    assign o_out_data.tan_y      = w_frame.tan_y;
    assign o_out_data.tan_z      = w_frame.tan_z;
    assign o_out_data.bitan_x    = w_frame.bitan_x;
    assign o_out_data.bitan_y    = w_frame.bitan_y;
    assign o_out_data.bitan_z    = w_frame.bitan_z;
    assign o_out_data.degenerate = w_frame.degenerate;
    assign o_out_data.corner     = w_corner;
    assign o_out_data.last       = w_last;

endmodule

// ===== tb/sv/triangle_tangent_frame_core_test.sv =====
// Self-checking bench for the triangle tangent frame core: drives vertex
// transactions, predicts each tangent frame in software and checks every output.
// Depends on ttf_pkg and triangle_tangent_frame_core.
`timescale 1ns / 1ps
module triangle_tangent_frame_core_test;
    import ttf_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_HOLD    = 1500;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_data;

    triangle_tangent_frame_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    // Pending vertices, each with a flag asking the driver to drain first.
    t_in_item  vertex_queue[$];
    bit        drain_queue[$];
    t_out_item frame_queue[$];

    // Predictor state: the two held corners and the slot counter.
    logic signed [63:0] held_px[2], held_py[2], held_pz[2], held_tu[2], held_tv[2];
    int unsigned corner_slot;

    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned frames_seen;
    int unsigned degen_seen;
    int unsigned hold_left;
    bit          hold_done;
    bit          quiet_phase;
    bit          stim_done;

    initial begin
        i_clk = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    // Normalises one vector into Q1.14; returns zero when its length is zero.
    function automatic bit unit_vector(input logic signed [127:0] c[3],
                                       output logic signed [15:0] q[3]);
        logic [127:0] m[3];
        logic [127:0] all_bits;
        logic [63:0]  v[3];
        logic [63:0]  sum, len, rem, bitv, rnd;
        int           bl, sh, i;
        all_bits = '0;
        sum = '0;
        for (i = 0; i < 3; i++) begin
            m[i] = c[i][127] ? -c[i] : c[i];
            all_bits |= m[i];
        end
        if (all_bits == 0) return 1'b0;
        bl = 0;
        for (i = 0; i < 128; i++) if (all_bits[i]) bl = i + 1;
        sh = bl > 31 ? bl - 31 : 0;
        for (i = 0; i < 3; i++) begin
            v[i] = 64'(m[i] >> sh);
            sum += v[i] * v[i];
        end
        // Bit-pair integer square root.
        rem = sum;
        len = '0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= len + bitv) begin
                rem -= len + bitv;
                len = (len >> 1) + bitv;
            end else begin
                len >>= 1;
            end
            bitv >>= 2;
        end
        if (len == 0) return 1'b0;
        for (i = 0; i < 3; i++) begin
            rnd = ((v[i] << OUT_FRAC) * 2 + len) / (2 * len);
            q[i] = c[i][127] ? -16'(rnd) : 16'(rnd);
        end
        return 1'b1;
    endfunction

    // Takes one vertex; on the third corner queues the three expected frames.
    task automatic predict_vertex(input t_in_item it);
        logic signed [63:0]  px, py, pz, tu, tv;
        logic signed [63:0]  e1[3], e2[3], du1, dv1, du2, dv2;
        logic signed [127:0] det, tc[3], bc[3];
        logic signed [15:0]  tq[3], bq[3];
        bit                  degen;
        t_out_item           o;
        int                  i;
        px = it.pos_x; py = it.pos_y; pz = it.pos_z; tu = it.tex_u; tv = it.tex_v;
        if (corner_slot < 2) begin
            held_px[corner_slot] = px; held_py[corner_slot] = py;
            held_pz[corner_slot] = pz; held_tu[corner_slot] = tu;
            held_tv[corner_slot] = tv;
            corner_slot++;
            return;
        end
        corner_slot = 0;
        e1[0] = held_px[1] - held_px[0]; e2[0] = px - held_px[0];
        e1[1] = held_py[1] - held_py[0]; e2[1] = py - held_py[0];
        e1[2] = held_pz[1] - held_pz[0]; e2[2] = pz - held_pz[0];
        du1 = held_tu[1] - held_tu[0]; dv1 = held_tv[1] - held_tv[0];
        du2 = tu - held_tu[0];         dv2 = tv - held_tv[0];
        for (i = 0; i < 3; i++) begin
            tq[i] = '0;
            bq[i] = '0;
        end
        det = 128'(du1) * 128'(dv2) - 128'(du2) * 128'(dv1);
        degen = (det == 0);
        if (!degen) begin
            for (i = 0; i < 3; i++) begin
                tc[i] = 128'(dv2) * 128'(e1[i]) - 128'(dv1) * 128'(e2[i]);
                bc[i] = 128'(du1) * 128'(e2[i]) - 128'(du2) * 128'(e1[i]);
                if (det < 0) begin
                    tc[i] = -tc[i];
                    bc[i] = -bc[i];
                end
            end
            if (!unit_vector(tc, tq) || !unit_vector(bc, bq)) begin
                degen = 1'b1;
                for (i = 0; i < 3; i++) begin
                    tq[i] = '0;
                    bq[i] = '0;
                end
            end
        end
        for (i = 0; i < 3; i++) begin
            o.tan_x = tq[0]; o.tan_y = tq[1]; o.tan_z = tq[2];
            o.bitan_x = bq[0]; o.bitan_y = bq[1]; o.bitan_z = bq[2];
            o.degenerate = degen;
            o.corner = 2'(i);
            o.last = (i == 2);
            frame_queue.push_back(o);
        end
    endtask

    function automatic logic [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
            default: return 32'($signed($urandom_range(0, 512)) - 256) <<< 16;
        endcase
    endfunction

    function automatic t_in_item rand_vertex(input int mode);
        t_in_item it;
        it.pos_x = rand_coord(mode); it.pos_y = rand_coord(mode);
        it.pos_z = rand_coord(mode); it.tex_u = rand_coord(mode);
        it.tex_v = rand_coord(mode);
        return it;
    endfunction

    function automatic t_in_item make_vertex(input logic [31:0] x, y, z, u, v);
        t_in_item it;
        it.pos_x = x; it.pos_y = y; it.pos_z = z; it.tex_u = u; it.tex_v = v;
        return it;
    endfunction

    task automatic add_vertex(input t_in_item it, input bit drain);
        vertex_queue.push_back(it);
        drain_queue.push_back(drain);
    endtask

    // Stimulus: directed triangles first, then random ones.
    initial begin
        t_in_item base;
        int       t, k, mode;
        // A plain unit triangle, then a mirrored UV one with a negative det.
        add_vertex(make_vertex(0, 0, 0, 0, 0), 1'b0);
        add_vertex(make_vertex(32'h10000, 0, 0, 32'h10000, 0), 1'b0);
        add_vertex(make_vertex(0, 32'h10000, 0, 0, 32'h10000), 1'b0);
        add_vertex(make_vertex(0, 0, 0, 0, 0), 1'b0);
        add_vertex(make_vertex(32'h10000, 0, 0, 32'hFFFF0000, 0), 1'b0);
        add_vertex(make_vertex(0, 32'h10000, 0, 0, 32'h10000), 1'b0);
        // Zero determinant: collinear UVs.
        add_vertex(make_vertex(0, 0, 0, 0, 0), 1'b0);
        add_vertex(make_vertex(32'h10000, 0, 0, 32'h10000, 32'h10000), 1'b0);
        add_vertex(make_vertex(0, 32'h10000, 0, 32'h20000, 32'h20000), 1'b0);
        // Zero-length vectors: all positions equal, UVs fine.
        add_vertex(make_vertex(5, 5, 5, 0, 0), 1'b0);
        add_vertex(make_vertex(5, 5, 5, 32'h10000, 0), 1'b0);
        add_vertex(make_vertex(5, 5, 5, 0, 32'h10000), 1'b0);
        // Field extremes: most negative and most positive values, then values near zero.
        add_vertex(make_vertex(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                               32'h80000000, 32'h7FFFFFFF), 1'b0);
        add_vertex(make_vertex(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                               32'h7FFFFFFF, 32'h80000000), 1'b0);
        add_vertex(make_vertex(32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                               32'h7FFFFFFF, 32'h7FFFFFFF), 1'b0);
        add_vertex(make_vertex(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                               32'hFFFFFFFF, 32'hFFFFFFFF), 1'b0);
        add_vertex(make_vertex(0, 1, 32'hFFFFFFFF, 1, 0), 1'b0);
        add_vertex(make_vertex(1, 0, 0, 0, 1), 1'b0);
        // Random triangles; later corners repeat a spare vertex one time in five.
        for (t = 0; t < 88; t++) begin
            mode = $urandom_range(0, 2);
            base = rand_vertex(mode);
            for (k = 0; k < 3; k++) begin
                if (k > 0 && $urandom_range(0, 4) == 0) begin
                    add_vertex(base, (t == 40 && k == 0));
                end else begin
                    add_vertex(rand_vertex(mode), (t == 40 && k == 0));
                end
            end
        end
    end

    // Driver: offers vertices, idling now and then outside the quiet phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
        end else if (i_in_valid && o_in_stall) begin
            // Hold the stalled transaction unchanged.
        end else begin
            if (i_in_valid) predict_vertex(i_in_data);
            if (vertex_queue.size() == 0) begin
                i_in_valid <= 1'b0;
                if (i_in_valid || !stim_done) stim_done <= (vertex_queue.size() == 0);
            end else if (drain_queue[0] && (frame_queue.size() != 0 || i_in_valid)) begin
                i_in_valid <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 99) < 10) begin
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid <= 1'b1;
                i_in_data  <= vertex_queue.pop_front();
                void'(drain_queue.pop_front());
            end
        end
    end

    // Receiver stall: one long hold-off once a few frames are done, else random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left   <= 0;
            hold_done   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= (hold_left != 1);
        end else if (!hold_done && frames_seen >= 30) begin
            hold_done   <= 1'b1;
            hold_left   <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet_phase && ($urandom_range(0, 99) < 10);
        end
    end

    // Monitor: compares each output transaction with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            frames_seen <= frames_seen + 1;
            if (o_out_data.degenerate) degen_seen <= degen_seen + 1;
            if (frame_queue.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10) $display("unexpected output %h", o_out_data);
            end else begin
                want = frame_queue.pop_front();
                if (want !== o_out_data) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("mismatch: expected %h got %h", want, o_out_data);
                end
            end
        end
    end

    // Cycle counter; the quiet phase spans a stretch with no random idling or stalling.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        quiet_phase <= (cycle_count >= 4000 && cycle_count < 9000);
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    // Reset and end of run.
    initial begin
        cycle_count    = 0;
        mismatch_count = 0;
        frames_seen    = 0;
        degen_seen     = 0;
        stim_done      = 1'b0;
        quiet_phase    = 1'b0;
        corner_slot    = 0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_out_stall    = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && frame_queue.size() == 0);
        repeat (400) @(posedge i_clk);
        $display("Checked %0d frame outputs, %0d of them degenerate, over %0d cycles.",
                 frames_seen, degen_seen, cycle_count);
        if (mismatch_count == 0 && frame_queue.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("tb: failure");
        end
        $finish;
    end
endmodule
